FILE: src/assert_macros.svh
// Assertion macros shared by the particle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property every clock unless in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition implies a property in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

FILE: src/ptue_pkg.sv
// Package with request/result types and constants of the particle table engine.
`timescale 1ns / 1ps
package ptue_pkg;

  typedef enum logic [1:0] {
    REQ_SPAWN = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         slot_sel;
    logic signed [15:0] spawn_x;
    logic signed [15:0] spawn_y;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic [31:0]        first_color;
    logic [31:0]        last_color;
    logic [15:0]        lifetime;
    logic [11:0]        first_size;
    logic [11:0]        last_size;
    logic [15:0]        tick_dt;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [4:0]         slot_out;
    logic               slot_active;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    logic [31:0]        cur_color;
    logic [11:0]        cur_size;
    logic [15:0]        life_left;
    logic [5:0]         live_count;
  } rsp_t;

  // One slot record as stored in memory.
  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [31:0]        col_s;
    logic [31:0]        col_e;
    logic [31:0]        col_n;
    logic [15:0]        life;
    logic [15:0]        maxl;
    logic [11:0]        sz_s;
    logic [11:0]        sz_e;
    logic [11:0]        sz_n;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_READ_WAIT,
    ST_READ_OUT,
    ST_TICK_RD,
    ST_TICK_WAIT,
    ST_TICK_MUL,
    ST_TICK_DIV,
    ST_TICK_BLEND,
    ST_TICK_WR,
    ST_CLEAR,
    ST_RESP
  } be_state_e;

  // Blend one 8 or 12 bit channel by t in Q1.8 (t up to 256).
  function automatic logic [11:0] blend12(input logic [11:0] a, input logic [11:0] b,
                                          input logic [8:0] t);
    logic [21:0] s;
    s = 22'(a) * 22'(9'd256 - t) + 22'(b) * 22'(t);
    return s[19:8];
  endfunction

endpackage

FILE: src/ptue_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module ptue_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/ptue_front.sv
// Front end: accepts requests into a short queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptue_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  ptue_pkg::req_t req_i,
  output logic          fq_valid_o,
  input  logic          fq_take_i,
  output ptue_pkg::req_t fq_req_o
);
  ptue_pkg::req_t buf_q [2];
  logic [1:0] cnt_q;
  logic rd_q, wr_q;
  logic do_push, do_pop;

  assign full       = (cnt_q == 2'd2);
  assign do_push    = push && !full;
  assign fq_valid_o = (cnt_q != 2'd0);
  assign do_pop     = fq_take_i && fq_valid_o;
  assign fq_req_o   = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  `ASSERT_CLK(a_cnt_range, clk_i, rst_ni, cnt_q <= 2'd2, "queue count overflow")
  `ASSERT_NEXT(a_push_cnt, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 2'd1,
               "push lost")
endmodule

FILE: src/ptue_back.sv
// Back end: carries out spawn, tick, read and clear on the slot table.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptue_back #(
  parameter int unsigned SlotCount = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fq_valid_i,
  output logic           fq_take_o,
  input  ptue_pkg::req_t fq_req_i,
  output logic           empty,
  input  logic           pop,
  output ptue_pkg::rsp_t rsp_o
);
  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned SlotW_c = ptue_pkg::SlotW;

  ptue_pkg::be_state_e st_q, st_d;
  logic [SlotCount-1:0] live_q, live_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic init_q, init_d;
  ptue_pkg::req_t req_q, req_d;
  ptue_pkg::rsp_t rsp_q, rsp_d;
  ptue_pkg::rsp_t acc_q, acc_d;
  logic rsp_v_q, rsp_v_d;
  ptue_pkg::slot_t cur_q, cur_d;
  logic signed [32:0] mx_q, my_q, mx_d, my_d;
  logic [8:0] r_q, r_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic [16:0] rem_q, rem_d;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  ptue_pkg::slot_t wdata, rdata;
  logic [SlotW_c-1:0] rdata_raw;

  ptue_ram #(.Width(SlotW_c), .Depth(SlotCount)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );
  assign rdata = ptue_pkg::slot_t'(rdata_raw);

  logic [CntW-1:0] cnt_live;
  logic [5:0] cnt_sat;
  logic [IdxW-1:0] free_idx;
  logic free_found;
  logic sel_ok;

  always_comb begin
    cnt_live = '0;
    free_idx = '0;
    free_found = 1'b0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_idx = IdxW'(i);
        free_found = 1'b1;
      end
    end
    for (int i = 0; i < SlotCount; i++) begin
      cnt_live = cnt_live + CntW'(live_q[i]);
    end
  end

  assign cnt_sat = (CntW > 6 && (cnt_live >> 6) != '0) ? 6'd63 : 6'(cnt_live);
  assign sel_ok  = (32'(fq_req_i.slot_sel) < SlotCount);

  assign empty = !rsp_v_q;
  assign rsp_o = rsp_q;

  // Tick arithmetic helpers
  logic signed [32:0] sx, sy;
  logic signed [15:0] nx, ny;
  logic [15:0] step, nlife;
  logic [8:0] tval;
  logic [17:0] rem_sub;
  logic [11:0] col_mix [4];

  always_comb begin
    sx = 33'(cur_q.px) + (mx_q >>> 16);
    sy = 33'(cur_q.py) + (my_q >>> 16);
    nx = (sx > 33'sd32767) ? 16'sh7fff : (sx < -33'sd32768) ? 16'sh8000 : sx[15:0];
    ny = (sy > 33'sd32767) ? 16'sh7fff : (sy < -33'sd32768) ? 16'sh8000 : sy[15:0];
    step  = {8'd0, req_q.tick_dt[15:8]};
    nlife = (cur_q.life > step) ? cur_q.life - step : 16'd0;
    tval  = (cur_q.maxl == 16'd0) ? 9'd256 : 9'd256 - r_q;
    rem_sub = 18'(rem_q) - 18'(cur_q.maxl);
    for (int k = 0; k < 4; k++) begin
      col_mix[k] = ptue_pkg::blend12({4'd0, cur_q.col_s[8*k +: 8]},
                                     {4'd0, cur_q.col_e[8*k +: 8]}, tval);
    end
  end

  always_comb begin
    st_d = st_q;
    live_d = live_q;
    idx_d = idx_q;
    init_d = init_q;
    req_d = req_q;
    rsp_d = rsp_q;
    acc_d = acc_q;
    rsp_v_d = rsp_v_q;
    cur_d = cur_q;
    mx_d = mx_q;
    my_d = my_q;
    r_d = r_q;
    dcnt_d = dcnt_q;
    rem_d = rem_q;
    fq_take_o = 1'b0;
    we = 1'b0;
    waddr = idx_q;
    wdata = cur_q;
    raddr = idx_q;
    if (rsp_v_q && pop) rsp_v_d = 1'b0;

    unique case (st_q)
      ptue_pkg::ST_IDLE: begin
        if (fq_valid_i) begin
          fq_take_o = 1'b1;
          req_d = fq_req_i;
          acc_d = '0;
          idx_d = '0;
          unique case (ptue_pkg::req_type_e'(fq_req_i.req_type))
            ptue_pkg::REQ_SPAWN: st_d = ptue_pkg::ST_SPAWN;
            ptue_pkg::REQ_TICK:  st_d = ptue_pkg::ST_TICK_RD;
            ptue_pkg::REQ_READ: begin
              acc_d.slot_out = fq_req_i.slot_sel;
              idx_d = IdxW'(fq_req_i.slot_sel);
              raddr = IdxW'(fq_req_i.slot_sel);
              st_d = sel_ok ? ptue_pkg::ST_READ_WAIT : ptue_pkg::ST_RESP;
            end
            default: st_d = ptue_pkg::ST_CLEAR;
          endcase
        end
      end
      ptue_pkg::ST_SPAWN: begin
        if (!free_found) begin
          acc_d.status = 1'b1;
        end else begin
          we = 1'b1;
          waddr = free_idx;
          wdata = '{px: req_q.spawn_x, py: req_q.spawn_y, vx: req_q.speed_x,
                    vy: req_q.speed_y, col_s: req_q.first_color,
                    col_e: req_q.last_color, col_n: req_q.first_color,
                    life: req_q.lifetime, maxl: req_q.lifetime,
                    sz_s: req_q.first_size, sz_e: req_q.last_size,
                    sz_n: req_q.first_size};
          live_d[free_idx] = 1'b1;
          acc_d.slot_out = 5'(free_idx);
        end
        st_d = ptue_pkg::ST_RESP;
      end
      ptue_pkg::ST_READ_WAIT: st_d = ptue_pkg::ST_READ_OUT;
      ptue_pkg::ST_READ_OUT: begin
        acc_d.slot_active = live_q[idx_q];
        acc_d.cur_x = rdata.px;
        acc_d.cur_y = rdata.py;
        acc_d.cur_color = rdata.col_n;
        acc_d.cur_size = rdata.sz_n;
        acc_d.life_left = rdata.life;
        st_d = ptue_pkg::ST_RESP;
      end
      ptue_pkg::ST_TICK_RD: begin
        if (live_q[idx_q]) begin
          st_d = ptue_pkg::ST_TICK_WAIT;
        end else if (32'(idx_q) == SlotCount - 1) begin
          st_d = ptue_pkg::ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ptue_pkg::ST_TICK_WAIT: begin
        cur_d = rdata;
        st_d = ptue_pkg::ST_TICK_MUL;
      end
      ptue_pkg::ST_TICK_MUL: begin
        mx_d = 33'(cur_q.vx) * $signed({1'b0, req_q.tick_dt});
        my_d = 33'(cur_q.vy) * $signed({1'b0, req_q.tick_dt});
        cur_d.life = nlife;
        rem_d = {1'b0, nlife};
        r_d = '0;
        dcnt_d = '0;
        st_d = ptue_pkg::ST_TICK_DIV;
      end
      ptue_pkg::ST_TICK_DIV: begin
        // restoring division of life*256 by maxl, one quotient bit per cycle
        if (cur_q.maxl != 16'd0 && !rem_sub[17]) begin
          rem_d = {rem_sub[15:0], 1'b0};
          r_d = {r_q[7:0], 1'b1};
        end else begin
          rem_d = {rem_q[15:0], 1'b0};
          r_d = {r_q[7:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd8) st_d = ptue_pkg::ST_TICK_BLEND;
      end
      ptue_pkg::ST_TICK_BLEND: begin
        cur_d.px = nx;
        cur_d.py = ny;
        for (int k = 0; k < 4; k++) begin
          cur_d.col_n[8*k +: 8] = col_mix[k][7:0];
        end
        cur_d.sz_n = ptue_pkg::blend12(cur_q.sz_s, cur_q.sz_e, tval);
        st_d = ptue_pkg::ST_TICK_WR;
      end
      ptue_pkg::ST_TICK_WR: begin
        we = 1'b1;
        if (cur_q.life == 16'd0) live_d[idx_q] = 1'b0;
        if (32'(idx_q) == SlotCount - 1) begin
          st_d = ptue_pkg::ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d = ptue_pkg::ST_TICK_RD;
        end
      end
      ptue_pkg::ST_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        live_d = '0;
        if (32'(idx_q) == SlotCount - 1) begin
          init_d = 1'b0;
          st_d = init_q ? ptue_pkg::ST_IDLE : ptue_pkg::ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ptue_pkg::ST_RESP: begin
        if (!rsp_v_q || pop) begin
          rsp_d = acc_q;
          rsp_d.live_count = cnt_sat;
          rsp_v_d = 1'b1;
          st_d = ptue_pkg::ST_IDLE;
        end
      end
      default: st_d = ptue_pkg::ST_IDLE;
    endcase
    // r beyond 256 clamps (quotient at most 9 bits, saturate when life exceeds maxl)
    if (st_q == ptue_pkg::ST_TICK_DIV && dcnt_q == 5'd8 &&
        (cur_q.life > cur_q.maxl || r_d > 9'd256)) begin
      r_d = 9'd256;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    acc_q <= acc_d;
    cur_q <= cur_d;
    mx_q <= mx_d;
    my_q <= my_d;
    r_q <= r_d;
    rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ptue_pkg::ST_CLEAR;
      live_q <= '0;
      idx_q <= '0;
      init_q <= 1'b1;
      rsp_v_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      st_q <= st_d;
      live_q <= live_d;
      idx_q <= idx_d;
      init_q <= init_d;
      rsp_v_q <= rsp_v_d;
      dcnt_q <= dcnt_d;
    end
  end

  `ASSERT_NEXT(a_take_leaves_idle, clk_i, rst_ni, fq_take_o, st_q != ptue_pkg::ST_IDLE,
               "request taken but engine stayed idle")
  `ASSERT_CLK(a_take_only_idle, clk_i, rst_ni, !fq_take_o || st_q == ptue_pkg::ST_IDLE,
              "request taken while busy")
endmodule

FILE: src/particle_table_update_engine_core.sv
// Top level of the particle table update engine.
`timescale 1ns / 1ps
// Usage:
//   Requests enter through a queue port: drive req_i and push; the request is
//   taken on a clock edge with push high and full low. A two-entry queue sits
//   in front of the engine so the sender can run ahead.
//   Results leave through a queue port: while empty is low, rsp_o holds the
//   oldest result; pop high on that edge takes it. One result per request.
//   A tick walks all slots in turn: an inactive slot is passed over, and an
//   active slot is read, moved by its speed, run through the bit-serial
//   life/max_life divider (9 steps), blended and written back through the
//   one-slot-at-a-time table memory port.
//   Requests are handled one at a time in order.
//   Reset empties both queues and marks every slot inactive; a clearing pass
//   then zeroes the slot memory before the first request is served.
//   When the receiver stalls, the finished result waits in the output
//   register and the engine holds the next result until it is popped.
module particle_table_update_engine_core #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  ptue_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output ptue_pkg::rsp_t rsp_o
);
  logic           fq_valid, fq_take;
  ptue_pkg::req_t fq_req;

  ptue_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .fq_valid_o (fq_valid),
    .fq_take_i  (fq_take),
    .fq_req_o   (fq_req)
  );

  ptue_back #(.SlotCount(SLOT_COUNT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fq_valid_i (fq_valid),
    .fq_take_o  (fq_take),
    .fq_req_i   (fq_req),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp_o)
  );
endmodule
